### sv/blpw_pkg.sv
// ----------------------------------------------------------------------------
// Bresenham line pixel walker package
// Shared widths, command codes and the structs that pass line parameters and
// pixel results between the walker's modules.
// ----------------------------------------------------------------------------
package blpw_pkg;

   // Coordinate width; endpoints use only this many low bits.
   localparam int CoordBits = 11;
   // Framebuffer address and row pitch widths.
   localparam int AddrBits  = 22;
   localparam int PitchBits = 12;
   localparam int ColorBits = 32;
   // Doubled deltas and the signed error term.
   localparam int DeltaBits = CoordBits + 1;
   localparam int ErrBits   = CoordBits + 3;

   // Row pitch after reset.
   localparam logic [PitchBits-1:0] PitchReset = PitchBits'(640);

   // Command codes of an input beat.
   typedef enum logic [0:0] {
      CMD_BEGIN   = 1'b0,
      CMD_ADVANCE = 1'b1
   } command_type;

   // Everything that describes a line in flight.
   typedef struct packed {
      logic [AddrBits-1:0]        address;
      logic signed [ErrBits-1:0]  error;
      logic [CoordBits-1:0]       remaining;
      logic [AddrBits-1:0]        major_step;
      logic [AddrBits-1:0]        minor_step;
      logic [DeltaBits-1:0]       increment;
      logic [DeltaBits-1:0]       decrement;
      logic [ColorBits-1:0]       color;
   } line_params_type;

   // One pixel result.
   typedef struct packed {
      logic                  pixel_valid;
      logic [AddrBits-1:0]   pixel_address;
      logic [ColorBits-1:0]  pixel_color;
      logic                  last_pixel;
   } pixel_result_type;

endpackage

### sv/bresenham_line_pixel_walker_unit.sv
// Path: an accepted input beat passes the input register, then the result
// register, before its result is offered; while rsp_stall holds, the result
// waits in the result register.
// Throughput: one input beat and one pixel per cycle while rsp_stall is low, for
// begin and advance alike; the single step adder and error update keep pace every cycle.
// Reset: synchronous, active high; no line is active and row pitch is 640.
// ----------------------------------------------------------------------------
// Bresenham line pixel walker unit
// Top level: input register, line setup, stepper, result register and the
// row pitch register, with valid/stall handshakes on both channels.
// ----------------------------------------------------------------------------
module bresenham_line_pixel_walker_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [blpw_pkg::PitchBits-1:0]  csr_write_data,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_command,
   input  logic [10:0]                     req_start_x,
   input  logic [10:0]                     req_start_y,
   input  logic [10:0]                     req_end_x,
   input  logic [10:0]                     req_end_y,
   input  logic [31:0]                     req_line_color,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_pixel_valid,
   output logic [21:0]                     rsp_pixel_address,
   output logic [31:0]                     rsp_pixel_color,
   output logic                            rsp_last_pixel
);
   import blpw_pkg::*;

   logic [PitchBits-1:0] pitch_ff;
   logic                 in_valid_ff, in_valid_in;
   logic                 in_command_ff;
   logic [10:0]          in_start_x_ff, in_start_y_ff, in_end_x_ff, in_end_y_ff;
   logic [31:0]          in_color_ff;
   logic                 out_valid_ff, out_valid_in;
   pixel_result_type     out_ff;
   pixel_result_type     step_result;
   line_params_type      begin_params;
   logic                 req_beat, rsp_beat, move;
   logic                 in_is_begin;

   // Handshakes: the input register moves on whenever the result register
   // is empty or being emptied.
   assign req_beat    = req_valid && !req_stall;
   assign rsp_beat    = out_valid_ff && !rsp_stall;
   assign move        = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall   = in_valid_ff && !move;
   assign in_is_begin = (in_command_ff == CMD_BEGIN);

   // Row pitch register.
   always_ff @(posedge clock) begin
      if (reset) begin
         pitch_ff <= PitchReset;
      end else if (csr_write_enable) begin
         pitch_ff <= csr_write_data;
      end
   end

   // Input register valid.
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_beat) begin
         in_valid_in = 1'b1;
      end else if (move) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // Input register payload.
   always_ff @(posedge clock) begin
      if (req_beat) begin
         in_command_ff <= req_command;
         in_start_x_ff <= req_start_x;
         in_start_y_ff <= req_start_y;
         in_end_x_ff   <= req_end_x;
         in_end_y_ff   <= req_end_y;
         in_color_ff   <= req_line_color;
      end
   end

   // Line setup for a begin beat.
   blpw_setup u_setup (
      .start_x    (in_start_x_ff),
      .start_y    (in_start_y_ff),
      .end_x      (in_end_x_ff),
      .end_y      (in_end_y_ff),
      .line_color (in_color_ff),
      .row_pitch  (pitch_ff),
      .params     (begin_params)
   );

   // Stepper emits one result per beat that moves.
   blpw_step u_step (
      .clock        (clock),
      .reset        (reset),
      .fire         (move),
      .is_begin     (in_is_begin),
      .begin_params (begin_params),
      .result       (step_result)
   );

   // Result register valid.
   always_comb begin
      out_valid_in = out_valid_ff;
      if (move) begin
         out_valid_in = 1'b1;
      end else if (rsp_beat) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   // Result register payload.
   always_ff @(posedge clock) begin
      if (move) begin
         out_ff <= step_result;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_pixel_valid   = out_ff.pixel_valid;
   assign rsp_pixel_address = out_ff.pixel_address;
   assign rsp_pixel_color   = out_ff.pixel_color;
   assign rsp_last_pixel    = out_ff.last_pixel;

`ifndef SYNTH
   // A result with no pixel carries only zeros.
   a_empty_result_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ff.pixel_valid) |->
      (out_ff.pixel_address == '0 && out_ff.pixel_color == '0 && !out_ff.last_pixel))
      else $error("empty result carries nonzero fields");

   // Only a real pixel can be the last one of a line.
   a_last_is_pixel: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.last_pixel) |-> out_ff.pixel_valid)
      else $error("last pixel flagged on empty result");

   // The input side is never stalled while the input register is empty.
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("input stalled with empty input register");

   // A held input item stays until it moves to the result register.
   a_held_item_kept: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !move) |=> (in_valid_ff && $stable(in_command_ff)))
      else $error("held input item lost");

   // Every move fills the result register on the next edge.
   a_move_fills_output: assert property (@(posedge clock) disable iff (reset)
      move |=> out_valid_ff)
      else $error("moved item did not reach result register");
`endif

endmodule

### sv/blpw_setup.sv
// ----------------------------------------------------------------------------
// Line setup
// Turns two endpoints, a color and the row pitch into the walker's line
// parameters: major axis, address steps, error terms and start address.
// ----------------------------------------------------------------------------
module blpw_setup (
   input  logic [10:0]                       start_x,
   input  logic [10:0]                       start_y,
   input  logic [10:0]                       end_x,
   input  logic [10:0]                       end_y,
   input  logic [31:0]                       line_color,
   input  logic [blpw_pkg::PitchBits-1:0]    row_pitch,
   output blpw_pkg::line_params_type         params
);
   import blpw_pkg::*;

   logic [CoordBits-1:0]           sx, sy, ex, ey;
   logic [CoordBits:0]             dx, dy;
   logic                           x_neg, y_neg;
   logic [CoordBits-1:0]           adx, ady;
   logic [AddrBits-1:0]            x_step, y_step, pitch_ext;
   logic                           x_major;
   logic [CoordBits-1:0]           span, minor_delta;
   logic [PitchBits+CoordBits-1:0] row_offset;

   // Coordinates are the low bits of the endpoint fields.
   assign sx = start_x[CoordBits-1:0];
   assign sy = start_y[CoordBits-1:0];
   assign ex = end_x[CoordBits-1:0];
   assign ey = end_y[CoordBits-1:0];

   // Signed deltas and their magnitudes.
   assign dx    = {1'b0, ex} - {1'b0, sx};
   assign dy    = {1'b0, ey} - {1'b0, sy};
   assign x_neg = dx[CoordBits];
   assign y_neg = dy[CoordBits];
   assign adx   = x_neg ? CoordBits'(-dx) : dx[CoordBits-1:0];
   assign ady   = y_neg ? CoordBits'(-dy) : dy[CoordBits-1:0];

   // Address steps along each axis, two's complement modulo the address space.
   assign pitch_ext = AddrBits'(row_pitch);
   assign x_step    = x_neg ? '1 : AddrBits'(1);
   assign y_step    = y_neg ? AddrBits'(-pitch_ext) : pitch_ext;

   // X is the major axis when it is at least as long as Y.
   assign x_major     = (adx >= ady);
   assign span        = x_major ? adx : ady;
   assign minor_delta = x_major ? ady : adx;

   // Start address is x plus pitch times y.
   assign row_offset = row_pitch * sy;

   always_comb begin
      params.address    = AddrBits'(row_offset) + AddrBits'(sx);
      params.major_step = x_major ? x_step : y_step;
      params.minor_step = x_major ? y_step : x_step;
      params.increment  = {minor_delta, 1'b0};
      params.decrement  = {span, 1'b0};
      params.error      = $signed({2'b00, minor_delta, 1'b0}) - $signed({3'b000, span});
      params.remaining  = span;
      params.color      = line_color;
   end

endmodule

### sv/blpw_step.sv
// ----------------------------------------------------------------------------
// Line stepper
// Holds the active line, emits the current pixel and moves the walker on by
// one pixel with the Bresenham error update.
// ----------------------------------------------------------------------------
module blpw_step (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          fire,
   input  logic                          is_begin,
   input  blpw_pkg::line_params_type     begin_params,
   output blpw_pkg::pixel_result_type    result
);
   import blpw_pkg::*;

   logic                       active_ff, active_in;
   line_params_type            line_ff, line_in;
   line_params_type            cur;
   logic                       emit;
   logic                       err_pos;
   logic                       is_last;
   logic signed [ErrBits-1:0]  err_drop;

   // A begin beat takes its freshly set-up line; an advance uses the held one.
   assign cur     = is_begin ? begin_params : line_ff;
   assign emit    = is_begin || active_ff;
   assign is_last = (cur.remaining == '0);
   assign err_pos = (cur.error > 0);

   // Pixel result; an advance without a line gives an all-zero result.
   always_comb begin
      result.pixel_valid   = emit;
      result.pixel_address = emit ? cur.address : '0;
      result.pixel_color   = emit ? cur.color : '0;
      result.last_pixel    = emit && is_last;
   end

   // Next walker position and error.
   always_comb begin
      line_in          = cur;
      err_drop         = err_pos ? $signed({2'b00, cur.decrement}) : '0;
      line_in.address  = cur.address + cur.major_step + (err_pos ? cur.minor_step : '0);
      line_in.error    = cur.error - err_drop + $signed({2'b00, cur.increment});
      line_in.remaining = is_last ? cur.remaining : cur.remaining - 1'b1;
      active_in        = !is_last;
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else if (fire && emit) begin
         active_ff <= active_in;
      end
   end

   // Line registers.
   always_ff @(posedge clock) begin
      if (fire && emit) begin
         line_ff <= line_in;
      end
   end

endmodule

### dv/pixel_walk_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel walk checker
// Watches the request, response and row pitch ports of the line walker. It
// keeps its own copy of the walker state, predicts the pixel for every
// accepted request beat, and compares each response beat field by field.
// ----------------------------------------------------------------------------
module pixel_walk_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [blpw_pkg::PitchBits-1:0]  csr_write_data,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic                            req_command,
   input  logic [10:0]                     req_start_x,
   input  logic [10:0]                     req_start_y,
   input  logic [10:0]                     req_end_x,
   input  logic [10:0]                     req_end_y,
   input  logic [31:0]                     req_line_color,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic                            rsp_pixel_valid,
   input  logic [21:0]                     rsp_pixel_address,
   input  logic [31:0]                     rsp_pixel_color,
   input  logic                            rsp_last_pixel,
   output int                              mismatch_count,
   output int                              pixels_outstanding
);

   typedef logic [blpw_pkg::AddrBits-1:0] addr_type;

   // Shadow copy of the row pitch and of the line being walked.
   logic [blpw_pkg::PitchBits-1:0]  row_pitch_q;
   bit                              line_open;
   addr_type                        walk_addr;
   int                              walk_error;
   int                              walk_left;
   addr_type                        walk_major;
   addr_type                        walk_minor;
   int                              error_up;
   int                              error_down;
   logic [blpw_pkg::ColorBits-1:0]  walk_color;

   // Pixels predicted but not yet seen on the response port, oldest first.
   blpw_pkg::pixel_result_type expected_pixels[$];
   int errors = 0;

   // Emit the current pixel, then move one pixel along the line.
   function automatic blpw_pkg::pixel_result_type step_walker();
      blpw_pkg::pixel_result_type px;
      px.pixel_valid   = 1'b1;
      px.pixel_address = walk_addr;
      px.pixel_color   = walk_color;
      px.last_pixel    = (walk_left == 0);
      walk_addr = walk_addr + walk_major;
      if (walk_error > 0) begin
         walk_addr  = walk_addr + walk_minor;
         walk_error = walk_error - error_down;
      end
      walk_error = walk_error + error_up;
      if (walk_left == 0) begin
         line_open = 1'b0;
      end else begin
         walk_left = walk_left - 1;
      end
      return px;
   endfunction

   // Work out the pixel that one request beat produces.
   function automatic blpw_pkg::pixel_result_type predict_pixel(
      input logic        cmd,
      input logic [10:0] sx_in,
      input logic [10:0] sy_in,
      input logic [10:0] ex_in,
      input logic [10:0] ey_in,
      input logic [31:0] color);
      int       sx, sy, dx, dy, span;
      addr_type x_step, y_step;
      blpw_pkg::pixel_result_type px;
      px = '0;
      if (cmd == blpw_pkg::CMD_BEGIN) begin
         sx = int'(sx_in);
         sy = int'(sy_in);
         dx = int'(ex_in) - sx;
         dy = int'(ey_in) - sy;
         x_step = addr_type'(1);
         y_step = addr_type'(row_pitch_q);
         // Negative deltas step backward: wrap the step modulo the address space.
         if (dy < 0) begin
            dy = -dy;
            y_step = addr_type'(0) - addr_type'(row_pitch_q);
         end
         if (dx < 0) begin
            dx = -dx;
            x_step = '1;
         end
         // X is the major axis on a tie.
         if (dx >= dy) begin
            span       = dx;
            walk_major = x_step;
            walk_minor = y_step;
            error_up   = 2 * dy;
         end else begin
            span       = dy;
            walk_major = y_step;
            walk_minor = x_step;
            error_up   = 2 * dx;
         end
         error_down = 2 * span;
         walk_error = error_up - span;
         walk_left  = span;
         walk_addr  = addr_type'(sx + int'(row_pitch_q) * sy);
         walk_color = color;
         line_open  = 1'b1;
         px = step_walker();
      end else if (line_open) begin
         px = step_walker();
      end
      return px;
   endfunction

   function automatic void check_field(input string field, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
         errors++;
      end
   endfunction

   // Track every beat at the clock edge; responses are matched before new
   // requests are queued so an early response cannot meet its own prediction.
   always @(posedge clock) begin
      blpw_pkg::pixel_result_type want;
      if (reset) begin
         row_pitch_q = blpw_pkg::PitchReset;
         line_open   = 1'b0;
         walk_addr   = '0;
         walk_error  = 0;
         walk_left   = 0;
         walk_major  = '0;
         walk_minor  = '0;
         error_up    = 0;
         error_down  = 0;
         walk_color  = '0;
         expected_pixels.delete();
      end else begin
         if (csr_write_enable) begin
            row_pitch_q = csr_write_data;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               $error("response beat arrived with no pixel predicted");
               errors++;
            end else begin
               want = expected_pixels.pop_front();
               check_field("pixel_valid", 32'(want.pixel_valid), 32'(rsp_pixel_valid));
               check_field("pixel_address", 32'(want.pixel_address),
                           32'(rsp_pixel_address));
               check_field("pixel_color", want.pixel_color, rsp_pixel_color);
               check_field("last_pixel", 32'(want.last_pixel), 32'(rsp_last_pixel));
            end
         end
         if (req_valid && !req_stall) begin
            expected_pixels.push_back(predict_pixel(req_command, req_start_x, req_start_y,
                                                    req_end_x, req_end_y, req_line_color));
         end
      end
      mismatch_count     <= errors;
      pixels_outstanding <= expected_pixels.size();
   end

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line walker testbench top
// Drives begin and advance beats through the line walker under random idling
// on both ports, changes the row pitch between phases, and reports the
// verdict from the checker's mismatch and outstanding pixel counts.
// ----------------------------------------------------------------------------
module tb_top;

   import blpw_pkg::*;

   localparam int HalfPeriod   = 5;
   localparam int SettleCycles = 8;
   localparam int LongHold     = 64;
   localparam int IdleLimit    = 3000;
   localparam int PhaseCount   = 6;
   localparam int RandomBeats  = 1000;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_write_enable;
   logic [PitchBits-1:0]  csr_write_data;
   logic                  req_valid;
   logic                  req_stall;
   logic                  req_command;
   logic [10:0]           req_start_x;
   logic [10:0]           req_start_y;
   logic [10:0]           req_end_x;
   logic [10:0]           req_end_y;
   logic [31:0]           req_line_color;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic                  rsp_pixel_valid;
   logic [21:0]           rsp_pixel_address;
   logic [31:0]           rsp_pixel_color;
   logic                  rsp_last_pixel;

   int mismatch_count;
   int pixels_outstanding;
   int beats_sent = 0;
   int quiet_cycles = 0;
   bit steady_sender = 1'b0;
   bit hold_go = 1'b0;
   bit hold_done = 1'b0;

   always #HalfPeriod clock = ~clock;

   bresenham_line_pixel_walker_unit dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_start_x       (req_start_x),
      .req_start_y       (req_start_y),
      .req_end_x         (req_end_x),
      .req_end_y         (req_end_y),
      .req_line_color    (req_line_color),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pixel_valid   (rsp_pixel_valid),
      .rsp_pixel_address (rsp_pixel_address),
      .rsp_pixel_color   (rsp_pixel_color),
      .rsp_last_pixel    (rsp_last_pixel)
   );

   pixel_walk_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_start_x        (req_start_x),
      .req_start_y        (req_start_y),
      .req_end_x          (req_end_x),
      .req_end_y          (req_end_y),
      .req_line_color     (req_line_color),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_pixel_valid    (rsp_pixel_valid),
      .rsp_pixel_address  (rsp_pixel_address),
      .rsp_pixel_color    (rsp_pixel_color),
      .rsp_last_pixel     (rsp_last_pixel),
      .mismatch_count     (mismatch_count),
      .pixels_outstanding (pixels_outstanding)
   );

   // Offer one request beat, hold it until accepted, then maybe go idle.
   task automatic send_beat(input command_type cmd, input logic [10:0] sx,
                            input logic [10:0] sy, input logic [10:0] ex,
                            input logic [10:0] ey, input logic [31:0] color);
      int dice, gap;
      req_valid      <= 1'b1;
      req_command    <= cmd;
      req_start_x    <= sx;
      req_start_y    <= sy;
      req_end_x      <= ex;
      req_end_y      <= ey;
      req_line_color <= color;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      beats_sent++;
      // Mostly back to back, sometimes a short gap, rarely a long one.
      gap  = 0;
      dice = $urandom_range(0, 99);
      if (!steady_sender && dice >= 70) begin
         gap = (dice < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      end
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop sending and wait until every predicted pixel has come back.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pixels_outstanding != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_pitch(input logic [PitchBits-1:0] pitch);
      csr_write_enable <= 1'b1;
      csr_write_data   <= pitch;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Coordinates favor the edges of the range now and then.
   function automatic logic [10:0] pick_coord();
      int dice;
      dice = $urandom_range(0, 99);
      if (dice < 12) return 11'd0;
      if (dice < 24) return 11'd2047;
      return 11'($urandom);
   endfunction

   function automatic logic [10:0] nearby(input logic [10:0] c, input int reach);
      int v;
      v = int'(c) + int'($urandom_range(0, 2 * reach)) - reach;
      if (v < 0) v = 0;
      if (v > 2047) v = 2047;
      return 11'(v);
   endfunction

   // One begin beat followed by advances; most lines are walked to the end,
   // some are cut short by the next begin and some run past their last pixel.
   task automatic walk_random_line();
      logic [10:0] sx, sy, ex, ey;
      int dice, span, steps;
      bit long_line;
      dice = $urandom_range(0, 99);
      steady_sender = ($urandom_range(0, 3) == 0);
      if (dice < 6) begin
         send_beat(CMD_ADVANCE, 11'($urandom), 11'($urandom), 11'($urandom),
                   11'($urandom), $urandom);
         return;
      end
      sx = pick_coord();
      sy = pick_coord();
      long_line = (dice < 16);
      if (long_line) begin
         ex = 11'($urandom);
         ey = 11'($urandom);
      end else if (dice < 24) begin
         ex = nearby(sx, 40);
         ey = nearby(sy, 40);
      end else begin
         ex = nearby(sx, 10);
         ey = nearby(sy, 10);
      end
      span = (int'(ex) > int'(sx)) ? int'(ex) - int'(sx) : int'(sx) - int'(ex);
      steps = (int'(ey) > int'(sy)) ? int'(ey) - int'(sy) : int'(sy) - int'(ey);
      if (steps > span) span = steps;
      dice = $urandom_range(0, 99);
      if (long_line) begin
         steps = $urandom_range(0, 6);
      end else if (dice < 70) begin
         steps = span;
      end else if (dice < 85) begin
         steps = $urandom_range(0, span);
      end else begin
         steps = span + $urandom_range(1, 3);
      end
      send_beat(CMD_BEGIN, sx, sy, ex, ey, $urandom);
      repeat (steps) begin
         send_beat(CMD_ADVANCE, 11'($urandom), 11'($urandom), 11'($urandom),
                   11'($urandom), $urandom);
      end
   endtask

   // Receiver: runs of random stall, one long hold-off when asked for.
   initial begin
      int dice, run_len;
      rsp_stall <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_go && !hold_done) begin
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            run_len   = LongHold;
         end else begin
            dice = $urandom_range(0, 99);
            if (dice < 45) begin
               rsp_stall <= 1'b0;
               run_len   = $urandom_range(1, 20);
            end else if (dice < 90) begin
               rsp_stall <= 1'b1;
               run_len   = $urandom_range(1, 3);
            end else begin
               rsp_stall <= 1'b1;
               run_len   = $urandom_range(8, 30);
            end
         end
         repeat (run_len) @(posedge clock);
      end
   end

   // Watchdog: end the run if neither port moves a beat for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IdleLimit) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Stimulus and verdict.
   initial begin
      int phase_end;
      logic [PitchBits-1:0] pitch;
      reset            <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_write_data   <= '0;
      req_valid        <= 1'b0;
      req_command      <= CMD_ADVANCE;
      req_start_x      <= '0;
      req_start_y      <= '0;
      req_end_x        <= '0;
      req_end_y        <= '0;
      req_line_color   <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed beats at the reset pitch.
      // Advance with no line active gives an empty pixel.
      send_beat(CMD_ADVANCE, '1, '1, '1, '1, '1);
      // Single-pixel line is its own last pixel; nothing stays active.
      send_beat(CMD_BEGIN, 11'd0, 11'd0, 11'd0, 11'd0, 32'h0000_0000);
      send_beat(CMD_ADVANCE, '0, '0, '0, '0, '0);
      // Full-range diagonal, dropped after a few pixels by the next begin.
      send_beat(CMD_BEGIN, 11'd0, 11'd0, 11'd2047, 11'd2047, 32'hFFFF_FFFF);
      repeat (3) send_beat(CMD_ADVANCE, '0, '0, '0, '0, '0);
      // X-major walking left.
      send_beat(CMD_BEGIN, 11'd2047, 11'd0, 11'd0, 11'd3, 32'hA5A5_5A5A);
      repeat (3) send_beat(CMD_ADVANCE, '1, '1, '1, '1, '1);
      // Y-major walking up and left.
      send_beat(CMD_BEGIN, 11'd5, 11'd2047, 11'd3, 11'd0, 32'h5A5A_A5A5);
      repeat (2) send_beat(CMD_ADVANCE, '0, '0, '0, '0, '0);
      // Short y-major line walked to its end and past it.
      send_beat(CMD_BEGIN, 11'd100, 11'd100, 11'd102, 11'd106, 32'h1234_5678);
      repeat (8) send_beat(CMD_ADVANCE, '0, '0, '0, '0, '0);
      // Single pixel at the far corner.
      send_beat(CMD_BEGIN, 11'd2047, 11'd2047, 11'd2047, 11'd2047, 32'h8000_0001);
      send_beat(CMD_ADVANCE, '1, '1, '1, '1, '1);

      // Random phases, each at its own row pitch; the extremes come first.
      for (int phase = 0; phase < PhaseCount; phase++) begin
         case (phase)
            0:       pitch = 12'd1;
            1:       pitch = 12'd4095;
            2:       pitch = 12'd0;
            3:       pitch = 12'd2048;
            default: pitch = 12'($urandom_range(1, 4095));
         endcase
         settle();
         write_pitch(pitch);
         // Receiver holds off for a long stretch while lines keep coming.
         if (phase == 0) begin
            hold_go <= 1'b1;
         end
         phase_end = beats_sent + RandomBeats / PhaseCount;
         while (beats_sent < phase_end) begin
            walk_random_line();
         end
      end

      settle();
      if (mismatch_count == 0 && pixels_outstanding == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
